>>> rtl/core/point_cloud_rotate_translate_defines.svh
// Assertion macros for the point cloud transform core.
// No dependencies; included by files that carry concurrent checks.
`ifndef POINT_CLOUD_ROTATE_TRANSLATE_DEFINES_SVH
`define POINT_CLOUD_ROTATE_TRANSLATE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PCRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PCRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PCRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/pcrt_pkg.sv
// Package for the point cloud transform core: widths, word types,
// register indexes and the coefficient sequencer states. No dependencies.
package pcrt_pkg;

    localparam int COORD_BITS     = 32;
    localparam int ANGLE_BITS     = 16;
    localparam int COEF_BITS      = 18;
    localparam int EXTRA_BITS     = 32;
    localparam int FRAC_BITS      = COEF_BITS - 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TILT    = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEADING = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_X = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_Y = CFG_INDEX_BITS'(3);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic        [EXTRA_BITS-1:0] point_extra;
        logic                         last_point;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic        [EXTRA_BITS-1:0] out_extra;
        logic                         out_last;
        logic                         clipped;
    } result_t;

    typedef enum logic [2:0] {
        CS_START,
        CS_ROTATE,
        CS_MAP,
        CS_PRODUCT,
        CS_READY
    } coef_state_t;

endpackage

>>> rtl/core/point_cloud_rotate_translate.sv
// Point cloud rigid transform: tilt/heading rotation plus x/y shift, saturated.
// Uses pcrt_pkg and point_cloud_rotate_translate_defines.svh.
//
//  channel | signals                                  | word
//  --------+------------------------------------------+-----------------
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//  point   | point_valid, point_ready, point          | pcrt_pkg::point_t
//  result  | result_valid, result_ready, result       | pcrt_pkg::result_t
//
// One point per cycle unless the result stalls or coefficients rebuild; a point
// passes four registers (input, multiply, sum/round, shift/saturate) to result.
// After reset or an angle write, the coefficient rebuild (20 CORDIC steps, one
// shared coefficient multiplier) holds point_ready low.
// A stalled result holds the full stages behind it while empty stages still
// fill; four words fit before point_ready drops. Nothing is dropped or repeated.
`include "point_cloud_rotate_translate_defines.svh"

module point_cloud_rotate_translate (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcrt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pcrt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                point_valid,
    output logic                                point_ready,
    input  pcrt_pkg::point_t                    point,
    output logic                                result_valid,
    input  logic                                result_ready,
    output pcrt_pkg::result_t                   result
);
    import pcrt_pkg::*;

    localparam int CORDIC_STEPS = 20;
    localparam int CNT_W        = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W     = 33;
    localparam int TURN_BITS    = 32;
    localparam int QSHIFT       = 30 - FRAC_BITS;
    localparam int PROD_W       = COORD_BITS + COEF_BITS;
    localparam int SUM_W        = PROD_W + 2;
    localparam int RND_W        = SUM_W - FRAC_BITS;
    localparam int TOT_W        = RND_W + 1;
    localparam int CPROD_W      = 2 * COEF_BITS;

    localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] PROD_LAST = CNT_W'(4);
    localparam logic [CNT_W-1:0] PROD_CC   = CNT_W'(1);
    localparam logic [CNT_W-1:0] PROD_CS   = CNT_W'(2);
    localparam logic [CNT_W-1:0] PROD_SC   = CNT_W'(3);

    localparam logic signed [CORDIC_W-1:0] GAIN_INIT = CORDIC_W'(652032874);
    localparam logic signed [CORDIC_W-1:0] Q_HALF    = CORDIC_W'(2 ** (QSHIFT - 1));
    localparam logic signed [CORDIC_W-1:0] COEF_ONE  = CORDIC_W'(2 ** FRAC_BITS);
    localparam logic signed [CORDIC_W-1:0] COEF_MONE = -COEF_ONE;
    localparam logic signed [CPROD_W-1:0]  CPROD_HALF = CPROD_W'(2 ** (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0]    SUM_HALF   = SUM_W'(2 ** (FRAC_BITS - 1));
    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [CNT_W-1:0] idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            5'd0:    v = CORDIC_W'(536870912);
            5'd1:    v = CORDIC_W'(316933406);
            5'd2:    v = CORDIC_W'(167458907);
            5'd3:    v = CORDIC_W'(85004756);
            5'd4:    v = CORDIC_W'(42667331);
            5'd5:    v = CORDIC_W'(21354465);
            5'd6:    v = CORDIC_W'(10679838);
            5'd7:    v = CORDIC_W'(5340245);
            5'd8:    v = CORDIC_W'(2670163);
            5'd9:    v = CORDIC_W'(1335087);
            5'd10:   v = CORDIC_W'(667544);
            5'd11:   v = CORDIC_W'(333772);
            5'd12:   v = CORDIC_W'(166886);
            5'd13:   v = CORDIC_W'(83443);
            5'd14:   v = CORDIC_W'(41722);
            5'd15:   v = CORDIC_W'(20861);
            5'd16:   v = CORDIC_W'(10430);
            5'd17:   v = CORDIC_W'(5215);
            5'd18:   v = CORDIC_W'(2608);
            5'd19:   v = CORDIC_W'(1304);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q30 to coefficient, round half up, clamp to +-1.0
    function automatic logic signed [COEF_BITS-1:0] to_coef(input logic signed [CORDIC_W-1:0] q);
        logic signed [CORDIC_W-1:0] r;
        r = (q + Q_HALF) >>> QSHIFT;
        if (r > COEF_ONE)
            r = COEF_ONE;
        if (r < COEF_MONE)
            r = COEF_MONE;
        return COEF_BITS'(r);
    endfunction

    // ---------------- configuration ----------------
    logic        [ANGLE_BITS-1:0] tilt_reg;
    logic        [ANGLE_BITS-1:0] heading_reg;
    logic signed [COORD_BITS-1:0] shift_x_reg;
    logic signed [COORD_BITS-1:0] shift_y_reg;
    logic                         angle_write;

    assign cfg_ready   = 1'b1;
    assign angle_write = cfg_valid && (cfg_index == REG_TILT || cfg_index == REG_HEADING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_reg    <= '0;
            heading_reg <= '0;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TILT:    tilt_reg    <= cfg_data[ANGLE_BITS-1:0];
                REG_HEADING: heading_reg <= cfg_data[ANGLE_BITS-1:0];
                REG_SHIFT_X: shift_x_reg <= cfg_data[COORD_BITS-1:0];
                REG_SHIFT_Y: shift_y_reg <= cfg_data[COORD_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // ---------------- coefficient sequencer ----------------
    coef_state_t      coef_state_reg, coef_state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             coef_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_state_reg <= CS_START;
            cnt_reg        <= '0;
        end
        else
        begin
            coef_state_reg <= coef_state_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_comb
    begin
        coef_state_next = coef_state_reg;
        cnt_next        = cnt_reg;
        case (coef_state_reg)
            CS_START:
            begin
                coef_state_next = CS_ROTATE;
                cnt_next        = '0;
            end
            CS_ROTATE:
            begin
                if (cnt_reg == ROT_LAST)
                begin
                    coef_state_next = CS_MAP;
                    cnt_next        = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            CS_MAP:
            begin
                coef_state_next = CS_PRODUCT;
                cnt_next        = '0;
            end
            CS_PRODUCT:
            begin
                if (cnt_reg == PROD_LAST)
                begin
                    coef_state_next = CS_READY;
                    cnt_next        = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            CS_READY: ;
            default:
            begin
                coef_state_next = CS_START;
                cnt_next        = '0;
            end
        endcase
        if (angle_write)
        begin
            coef_state_next = CS_START;
            cnt_next        = '0;
        end
    end

    assign coef_ready = (coef_state_reg == CS_READY);

    // two CORDIC lanes: 0 = tilt, 1 = heading
    logic        [ANGLE_BITS-1:0] ang [2];
    logic signed [CORDIC_W-1:0]   cx_reg [2];
    logic signed [CORDIC_W-1:0]   cy_reg [2];
    logic signed [CORDIC_W-1:0]   cz_reg [2];
    logic        [1:0]            quad_reg [2];
    logic signed [CORDIC_W-1:0]   cx_next [2];
    logic signed [CORDIC_W-1:0]   cy_next [2];
    logic signed [CORDIC_W-1:0]   cz_next [2];
    logic signed [CORDIC_W-1:0]   dx [2];
    logic signed [CORDIC_W-1:0]   dy [2];
    logic signed [CORDIC_W-1:0]   at_step;
    logic signed [COEF_BITS-1:0]  cc [2];
    logic signed [COEF_BITS-1:0]  ss [2];
    logic signed [COEF_BITS-1:0]  cos_map [2];
    logic signed [COEF_BITS-1:0]  sin_map [2];
    logic signed [COEF_BITS-1:0]  cos_reg [2];
    logic signed [COEF_BITS-1:0]  sin_reg [2];

    assign ang[0]  = tilt_reg;
    assign ang[1]  = heading_reg;
    assign at_step = atan_turn(cnt_reg);

    always_comb
    begin
        for (int u = 0; u < 2; u++)
        begin
            dx[u] = cy_reg[u] >>> cnt_reg;
            dy[u] = cx_reg[u] >>> cnt_reg;
            if (!cz_reg[u][CORDIC_W-1])
            begin
                cx_next[u] = cx_reg[u] - dx[u];
                cy_next[u] = cy_reg[u] + dy[u];
                cz_next[u] = cz_reg[u] - at_step;
            end
            else
            begin
                cx_next[u] = cx_reg[u] + dx[u];
                cy_next[u] = cy_reg[u] - dy[u];
                cz_next[u] = cz_reg[u] + at_step;
            end
            cc[u] = to_coef(cx_reg[u]);
            ss[u] = to_coef(cy_reg[u]);
            case (quad_reg[u])
                2'd0:
                begin
                    cos_map[u] = cc[u];
                    sin_map[u] = ss[u];
                end
                2'd1:
                begin
                    cos_map[u] = -ss[u];
                    sin_map[u] = cc[u];
                end
                2'd2:
                begin
                    cos_map[u] = -cc[u];
                    sin_map[u] = -ss[u];
                end
                default:
                begin
                    cos_map[u] = ss[u];
                    sin_map[u] = -cc[u];
                end
            endcase
        end
    end

    // shared coefficient multiplier
    logic signed [COEF_BITS-1:0] op_a, op_b, cround;
    logic signed [CPROD_W-1:0]   cprod_reg;

    always_comb
    begin
        case (cnt_reg)
            CNT_W'(0):
            begin
                op_a = cos_reg[0];
                op_b = cos_reg[1];
            end
            CNT_W'(1):
            begin
                op_a = cos_reg[0];
                op_b = sin_reg[1];
            end
            CNT_W'(2):
            begin
                op_a = sin_reg[0];
                op_b = cos_reg[1];
            end
            default:
            begin
                op_a = sin_reg[0];
                op_b = sin_reg[1];
            end
        endcase
    end

    assign cround = COEF_BITS'((cprod_reg + CPROD_HALF) >>> FRAC_BITS);

    // datapath coefficients per output row; z row has no y term
    logic signed [COEF_BITS-1:0] kx_reg [3];
    logic signed [COEF_BITS-1:0] ky_reg [3];
    logic signed [COEF_BITS-1:0] kz0_reg;
    logic signed [COEF_BITS-1:0] kz2_reg;

    always_ff @(posedge clk)
    begin
        case (coef_state_reg)
            CS_START:
            begin
                for (int u = 0; u < 2; u++)
                begin
                    cx_reg[u]   <= GAIN_INIT;
                    cy_reg[u]   <= '0;
                    cz_reg[u]   <= CORDIC_W'({ang[u][ANGLE_BITS-3:0],
                                              {(TURN_BITS-ANGLE_BITS){1'b0}}});
                    quad_reg[u] <= ang[u][ANGLE_BITS-1 -: 2];
                end
            end
            CS_ROTATE:
            begin
                for (int u = 0; u < 2; u++)
                begin
                    cx_reg[u] <= cx_next[u];
                    cy_reg[u] <= cy_next[u];
                    cz_reg[u] <= cz_next[u];
                end
            end
            CS_MAP:
            begin
                for (int u = 0; u < 2; u++)
                begin
                    cos_reg[u] <= cos_map[u];
                    sin_reg[u] <= sin_map[u];
                end
            end
            CS_PRODUCT:
            begin
                cprod_reg <= op_a * op_b;
                case (cnt_reg)
                    CNT_W'(0):
                    begin
                        kx_reg[1] <= cos_reg[1];
                        ky_reg[1] <= sin_reg[1];
                        kz0_reg   <= -sin_reg[0];
                        kz2_reg   <= cos_reg[0];
                    end
                    PROD_CC: ky_reg[0] <= cround;
                    PROD_CS: kx_reg[0] <= -cround;
                    PROD_SC: ky_reg[2] <= cround;
                    PROD_LAST: kx_reg[2] <= -cround;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // ---------------- point pipeline ----------------
    logic s1_en, s2_en, s3_en, s4_en, point_accept;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, result_valid_reg;

    point_t                       s1_pt_reg;
    logic signed [COORD_BITS-1:0] pc [3];
    logic signed [PROD_W-1:0]     prod [8];
    logic signed [PROD_W-1:0]     s2_prod_reg [8];
    logic        [EXTRA_BITS-1:0] s2_extra_reg;
    logic                         s2_last_reg;
    logic signed [SUM_W-1:0]      sum [3];
    logic signed [RND_W-1:0]      s3_rnd_reg [3];
    logic        [EXTRA_BITS-1:0] s3_extra_reg;
    logic                         s3_last_reg;
    logic signed [COORD_BITS-1:0] shv [3];
    logic signed [TOT_W-1:0]      tot [3];
    logic        [TOT_W-COORD_BITS:0] hi [3];
    logic        [2:0]            ovf;
    logic        [COORD_BITS-1:0] sat [3];
    result_t                      result_reg;

    assign s4_en        = !result_valid_reg || result_ready;
    assign s3_en        = !s3_valid_reg || s4_en;
    assign s2_en        = !s2_valid_reg || s3_en;
    assign s1_en        = !s1_valid_reg || s2_en;
    assign point_ready  = s1_en && coef_ready;
    assign point_accept = point_valid && point_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= point_accept;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
            if (s4_en)
                result_valid_reg <= s3_valid_reg;
        end
    end

    assign pc[0] = s1_pt_reg.point_x;
    assign pc[1] = s1_pt_reg.point_y;
    assign pc[2] = s1_pt_reg.point_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod[i]     = PROD_W'(pc[i]) * PROD_W'(kx_reg[i]);
            prod[3 + i] = PROD_W'(pc[i]) * PROD_W'(ky_reg[i]);
        end
        prod[6] = PROD_W'(pc[0]) * PROD_W'(kz0_reg);
        prod[7] = PROD_W'(pc[2]) * PROD_W'(kz2_reg);

        sum[0] = SUM_W'(s2_prod_reg[0]) + SUM_W'(s2_prod_reg[1])
               + SUM_W'(s2_prod_reg[2]) + SUM_HALF;
        sum[1] = SUM_W'(s2_prod_reg[3]) + SUM_W'(s2_prod_reg[4])
               + SUM_W'(s2_prod_reg[5]) + SUM_HALF;
        sum[2] = SUM_W'(s2_prod_reg[6]) + SUM_W'(s2_prod_reg[7]) + SUM_HALF;

        shv[0] = shift_x_reg;
        shv[1] = shift_y_reg;
        shv[2] = '0;
        for (int i = 0; i < 3; i++)
        begin
            tot[i] = TOT_W'(s3_rnd_reg[i]) + TOT_W'(shv[i]);
            hi[i]  = tot[i][TOT_W-1:COORD_BITS-1];
            ovf[i] = !((&hi[i]) || !(|hi[i]));
            if (ovf[i])
                sat[i] = tot[i][TOT_W-1] ? COORD_MIN : COORD_MAX;
            else
                sat[i] = tot[i][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
            s1_pt_reg <= point;
        if (s2_en)
        begin
            for (int i = 0; i < 8; i++)
                s2_prod_reg[i] <= prod[i];
            s2_extra_reg <= s1_pt_reg.point_extra;
            s2_last_reg  <= s1_pt_reg.last_point;
        end
        if (s3_en)
        begin
            for (int i = 0; i < 3; i++)
                s3_rnd_reg[i] <= sum[i][SUM_W-1:FRAC_BITS];
            s3_extra_reg <= s2_extra_reg;
            s3_last_reg  <= s2_last_reg;
        end
        if (s4_en)
        begin
            result_reg.out_x     <= sat[0];
            result_reg.out_y     <= sat[1];
            result_reg.out_z     <= sat[2];
            result_reg.out_extra <= s3_extra_reg;
            result_reg.out_last  <= s3_last_reg;
            result_reg.clipped   <= |ovf;
        end
    end

    // ---------------- checks ----------------
    `PCRT_ASSERT_NXT(a_angle_restart, clk, rst_n, angle_write,
        coef_state_reg == CS_START, "angle write did not restart coefficient build")
    `PCRT_ASSERT_NXT(a_rotate_to_map, clk, rst_n,
        coef_state_reg == CS_ROTATE && cnt_reg == ROT_LAST && !angle_write,
        coef_state_reg == CS_MAP, "CORDIC did not finish after last step")
    `PCRT_ASSERT_IMP(a_no_stale_accept, clk, rst_n, coef_state_reg != CS_READY,
        !point_ready, "point taken while coefficients rebuild")
    `PCRT_ASSERT_IMP(a_result_source, clk, rst_n, $rose(result_valid),
        $past(s3_valid_reg), "result valid without a word in the round stage")

endmodule
